// ===== hdl/ecs_pkg.sv =====
// Package for the emergency command sniffer.
// Holds the parser state type, the action codes, character constants and the result struct.
// No dependencies; the parser, the top level, the checker and the testbench import it.
package ecs_pkg;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic PARSER_ENABLE_RESET = 1'b1;

    typedef enum logic [4:0] {
        ST_START,
        ST_NUM,
        ST_M,
        ST_M1,
        ST_M10,
        ST_M108,
        ST_M11,
        ST_M112,
        ST_M4,
        ST_M41,
        ST_M410,
        ST_M8,
        ST_M87,
        ST_M876,
        ST_M876S,
        ST_M876SD,
        ST_SKIP
    } parser_state_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_CANCEL = 3'd1,
        ACT_KILL   = 3'd2,
        ACT_QSTOP  = 3'd3,
        ACT_HOST   = 3'd4
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [3:0] response_value;
        logic       kill_latched;
    } ecs_result_t;

endpackage

// ===== hdl/ecs_if.sv =====
// Channel interfaces of the emergency command sniffer: received bytes, results, configuration.
// Each carries valid, ready and the payload; no package dependency.
interface ecs_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ecs_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [3:0] response_value;
    logic       kill_latched;

    modport source (output valid, output action, output response_value,
                    output kill_latched, input ready);
    modport sink (input valid, input action, input response_value,
                  input kill_latched, output ready);
endinterface

interface ecs_cfg_if;
    logic valid;
    logic ready;
    logic parser_enable;

    modport source (output valid, output parser_enable, input ready);
    modport sink (input valid, input parser_enable, output ready);
endinterface

// ===== hdl/ecs_in_stage.sv =====
// Input register of the emergency command sniffer.
// Depends on ecs_if.sv (ecs_rx_if); holds one received byte until the parser takes it.
module ecs_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    ecs_rx_if.sink     rx,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    // accept while empty or while the held byte moves on this cycle
    assign rx.ready   = !valid_reg || advance;
    assign take       = rx.valid && rx.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

// ===== hdl/ecs_parser.sv =====
// Command parser of the emergency command sniffer: state register, response digit, kill flag.
// Depends on ecs_pkg (state type, action codes, character constants, result struct).
module ecs_parser
    import ecs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [7:0]  byte_data,
    input  logic        enable,
    output ecs_result_t result
);

    parser_state_t state_reg;
    parser_state_t state_next;
    logic [3:0]    digit_reg;
    logic [3:0]    digit_next;
    logic          kill_reg;
    logic          kill_next;
    action_t       action;
    logic          is_digit;
    logic [7:0]    digit_diff;

    assign is_digit   = byte_data inside {[CH_0:CH_9]};
    assign digit_diff = byte_data - CH_0;

    always_comb
    begin
        state_next = state_reg;
        digit_next = digit_reg;
        kill_next  = kill_reg;
        action     = ACT_NONE;
        case (state_reg)
            ST_START:
            begin
                if (byte_data == CH_SPACE)
                    state_next = ST_START;
                else if (byte_data == CH_N)
                    state_next = ST_NUM;
                else if (byte_data == CH_M)
                    state_next = ST_M;
                else
                    state_next = ST_SKIP;
            end
            ST_NUM:
            begin
                if (is_digit || byte_data == CH_DASH || byte_data == CH_SPACE)
                    state_next = ST_NUM;
                else if (byte_data == CH_M)
                    state_next = ST_M;
                else
                    state_next = ST_SKIP;
            end
            ST_M:
            begin
                if (byte_data == CH_SPACE)
                    state_next = ST_M;
                else if (byte_data == CH_1)
                    state_next = ST_M1;
                else if (byte_data == CH_4)
                    state_next = ST_M4;
                else if (byte_data == CH_8)
                    state_next = ST_M8;
                else
                    state_next = ST_SKIP;
            end
            ST_M1:
            begin
                if (byte_data == CH_0)
                    state_next = ST_M10;
                else if (byte_data == CH_1)
                    state_next = ST_M11;
                else
                    state_next = ST_SKIP;
            end
            ST_M10:  state_next = (byte_data == CH_8) ? ST_M108 : ST_SKIP;
            ST_M11:  state_next = (byte_data == CH_2) ? ST_M112 : ST_SKIP;
            ST_M4:   state_next = (byte_data == CH_1) ? ST_M41  : ST_SKIP;
            ST_M41:  state_next = (byte_data == CH_0) ? ST_M410 : ST_SKIP;
            ST_M8:   state_next = (byte_data == CH_7) ? ST_M87  : ST_SKIP;
            ST_M87:  state_next = (byte_data == CH_6) ? ST_M876 : ST_SKIP;
            ST_M876:
            begin
                if (byte_data == CH_SPACE)
                    state_next = ST_M876;
                else if (byte_data == CH_S)
                    state_next = ST_M876S;
                else
                    state_next = ST_SKIP;
            end
            ST_M876S:
            begin
                // hold here on anything but a digit, newline included
                if (is_digit)
                begin
                    state_next = ST_M876SD;
                    digit_next = digit_diff[3:0];
                end
            end
            ST_M108, ST_M112, ST_M410, ST_M876SD:
            begin
                if (byte_data == CH_NL)
                begin
                    state_next = ST_START;
                    if (enable)
                    begin
                        case (state_reg)
                            ST_M108: action = ACT_CANCEL;
                            ST_M112:
                            begin
                                action    = ACT_KILL;
                                kill_next = 1'b1;
                            end
                            ST_M410: action = ACT_QSTOP;
                            default: action = ACT_HOST;
                        endcase
                    end
                end
            end
            default:
            begin
                if (byte_data == CH_NL)
                    state_next = ST_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            digit_reg <= 4'd0;
            kill_reg  <= 1'b0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            digit_reg <= digit_next;
            kill_reg  <= kill_next;
        end
    end

    assign result.action         = action;
    assign result.response_value = digit_next;
    assign result.kill_latched   = kill_next;

endmodule

// ===== hdl/emergency_command_sniffer.sv =====
// Emergency command sniffer: watches a byte stream for M108, M112, M410 and M876 S<digit>.
// An accepted byte waits in the input register, then its result in the result register.
// Throughput: one byte per cycle unless a result waits; then the input register holds one.
// Reset (rst_n low, asynchronous): parser at line start, digit 0, kill flag clear, enable set.
// Depends on ecs_pkg, ecs_if.sv, ecs_in_stage and ecs_parser.
module emergency_command_sniffer
    import ecs_pkg::*;
#(
    parameter logic ENABLE_RESET = PARSER_ENABLE_RESET
)
(
    input  logic        clk,
    input  logic        rst_n,
    ecs_rx_if.sink      rx,
    ecs_result_if.source result,
    ecs_cfg_if.sink     cfg
);

    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        advance;
    logic        fire;
    logic        enable_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    ecs_result_t parsed;
    ecs_result_t out_reg;

    assign advance = !out_valid_reg || result.ready;
    assign fire    = byte_valid && advance;

    ecs_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    ecs_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .byte_data (byte_data),
        .enable    (enable_reg),
        .result    (parsed)
    );

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= ENABLE_RESET;
        end
        else if (cfg.valid)
        begin
            enable_reg <= cfg.parser_enable;
        end
    end

    assign out_valid_next = fire ? 1'b1 : (advance ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '{action: ACT_NONE, response_value: 4'd0, kill_latched: 1'b0};
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                out_reg <= parsed;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.action         = out_reg.action;
    assign result.response_value = out_reg.response_value;
    assign result.kill_latched   = out_reg.kill_latched;

endmodule

// ===== hdl/ecs_checker.sv =====
// Port-level checks for the emergency command sniffer, bound to the top level.
// Depends on ecs_pkg for the action codes.
module ecs_checker
    import ecs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] action,
    input logic [3:0] response_value,
    input logic       kill_latched
);

    // kill flag is sticky until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(kill_latched) |-> kill_latched)
        else $error("kill flag dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (action == ACT_KILL) |-> kill_latched)
        else $error("kill action without kill flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (response_value <= 4'd9))
        else $error("response digit out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(action)
            && $stable(response_value) && $stable(kill_latched))
        else $error("stalled result changed");

endmodule

bind emergency_command_sniffer ecs_checker u_ecs_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .action         (result.action),
    .response_value (result.response_value),
    .kill_latched   (result.kill_latched)
);

// ===== tb/sv/emergency_command_sniffer_tb.sv =====
// Self-checking testbench for emergency_command_sniffer: drives bytes and enable writes,
// predicts every result transaction and checks it field by field.
// Depends on ecs_pkg (hdl/ecs_pkg.sv) and the channel interfaces in hdl/ecs_if.sv.
module emergency_command_sniffer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ecs_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int STALL_CYCLES = 400;
    localparam int IDLE_PERCENT = 15;

    // Tracks the parser the way the block should, and holds the results still owed.
    class sniffer_scoreboard;
        parser_state_t state;
        logic [3:0]    digit;
        logic          kill_flag;
        logic          enable;
        ecs_result_t   owed_results[$];
        int            failures;

        function new();
            state     = ST_START;
            digit     = 4'd0;
            kill_flag = 1'b0;
            enable    = PARSER_ENABLE_RESET;
            failures  = 0;
        endfunction

        function void set_enable(logic value);
            enable = value;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function parser_state_t follow(logic [7:0] c, logic [7:0] want, parser_state_t nxt);
            return (c == want) ? nxt : ST_SKIP;
        endfunction

        function void note_byte(logic [7:0] c);
            action_t     act;
            ecs_result_t r;
            act = ACT_NONE;
            case (state)
                ST_START:
                    if (c == CH_N)
                        state = ST_NUM;
                    else if (c == CH_M)
                        state = ST_M;
                    else if (c != CH_SPACE)
                        state = ST_SKIP;
                ST_NUM:
                    if (c == CH_M)
                        state = ST_M;
                    else if (!(is_digit(c) || c == CH_DASH || c == CH_SPACE))
                        state = ST_SKIP;
                ST_M:
                    if (c == CH_1)
                        state = ST_M1;
                    else if (c == CH_4)
                        state = ST_M4;
                    else if (c == CH_8)
                        state = ST_M8;
                    else if (c != CH_SPACE)
                        state = ST_SKIP;
                ST_M1:
                    if (c == CH_0)
                        state = ST_M10;
                    else if (c == CH_1)
                        state = ST_M11;
                    else
                        state = ST_SKIP;
                ST_M10: state = follow(c, CH_8, ST_M108);
                ST_M11: state = follow(c, CH_2, ST_M112);
                ST_M4:  state = follow(c, CH_1, ST_M41);
                ST_M41: state = follow(c, CH_0, ST_M410);
                ST_M8:  state = follow(c, CH_7, ST_M87);
                ST_M87: state = follow(c, CH_6, ST_M876);
                ST_M876:
                    if (c == CH_S)
                        state = ST_M876S;
                    else if (c != CH_SPACE)
                        state = ST_SKIP;
                ST_M876S:
                    // hold here on anything but a digit, newline included
                    if (is_digit(c))
                    begin
                        state = ST_M876SD;
                        digit = 4'(c - CH_0);
                    end
                ST_M108, ST_M112, ST_M410, ST_M876SD:
                    if (c == CH_NL)
                    begin
                        if (enable)
                        begin
                            case (state)
                                ST_M108: act = ACT_CANCEL;
                                ST_M112:
                                begin
                                    act       = ACT_KILL;
                                    kill_flag = 1'b1;
                                end
                                ST_M410: act = ACT_QSTOP;
                                default: act = ACT_HOST;
                            endcase
                        end
                        state = ST_START;
                    end
                default:
                    if (c == CH_NL)
                        state = ST_START;
            endcase
            r.action         = act;
            r.response_value = digit;
            r.kill_latched   = kill_flag;
            owed_results.push_back(r);
        endfunction

        function void check_result(ecs_result_t got);
            ecs_result_t want;
            if (owed_results.size() == 0)
            begin
                $error("result transaction with none pending: action %0d", got.action);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            if (got.action !== want.action)
            begin
                $error("action: expected %0d, actual %0d", want.action, got.action);
                failures++;
            end
            if (got.response_value !== want.response_value)
            begin
                $error("response_value: expected %0d, actual %0d",
                       want.response_value, got.response_value);
                failures++;
            end
            if (got.kill_latched !== want.kill_latched)
            begin
                $error("kill_latched: expected %0d, actual %0d",
                       want.kill_latched, got.kill_latched);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ecs_rx_if     rx_ch();
    ecs_result_if res_ch();
    ecs_cfg_if    cfg_ch();

    emergency_command_sniffer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    sniffer_scoreboard sb;
    logic [7:0]        line_buf[$];
    bit                steady;
    bit                hold_request;
    int                bytes_sent;
    int                cycle_count;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("emergency_command_sniffer regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        ecs_result_t got;
        if (rst_n === 1'b1)
        begin
            if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
                sb.set_enable(cfg_ch.parser_enable);
            if (rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1)
                sb.note_byte(rx_ch.rx_byte);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                got.action         = action_t'(res_ch.action);
                got.response_value = res_ch.response_value;
                got.kill_latched   = res_ch.kill_latched;
                sb.check_result(got);
            end
        end
    end

    // Result side: random back-pressure, or one long hold-off on request.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                res_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (rx_ch.ready !== 1'b1) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic settle();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.owed_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.parser_enable <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed command lines with random content, some broken, some noise.
    function automatic void build_line();
        int         kind;
        int         n;
        logic [7:0] ch;
        line_buf.delete();
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            n = $urandom_range(1, 6);
            repeat (n) line_buf.push_back(8'($urandom_range(255)));
            line_buf.push_back(CH_NL);
            return;
        end
        repeat ($urandom_range(2)) line_buf.push_back(CH_SPACE);
        if ($urandom_range(2) == 0)
        begin
            line_buf.push_back(CH_N);
            repeat ($urandom_range(4))
            begin
                case ($urandom_range(2))
                    0: ch = CH_DASH;
                    1: ch = CH_SPACE;
                    default: ch = CH_0 + 8'($urandom_range(9));
                endcase
                line_buf.push_back(ch);
            end
        end
        line_buf.push_back(CH_M);
        if ($urandom_range(3) == 0)
            line_buf.push_back(CH_SPACE);
        case ($urandom_range(3))
            0: line_buf = {line_buf, CH_1, CH_0, CH_8};
            1: line_buf = {line_buf, CH_1, CH_1, CH_2};
            2: line_buf = {line_buf, CH_4, CH_1, CH_0};
            default:
            begin
                line_buf = {line_buf, CH_8, CH_7, CH_6};
                if ($urandom_range(1) == 0)
                    line_buf.push_back(CH_SPACE);
                line_buf.push_back(CH_S);
                while ($urandom_range(3) == 0)
                    line_buf.push_back(8'($urandom_range(255)));
                line_buf.push_back(CH_0 + 8'($urandom_range(9)));
            end
        endcase
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(32, 126)));
        if (kind < 30)
        begin
            if ($urandom_range(1) == 0)
            begin
                // cut the line short so the newline lands inside the prefix
                n = $urandom_range(line_buf.size() - 1);
                while (line_buf.size() > n) void'(line_buf.pop_back());
            end
            else
                line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
        end
        line_buf.push_back(CH_NL);
    endfunction

    task automatic run_lines(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            build_line();
            foreach (line_buf[i])
                send_byte(line_buf[i]);
        end
    endtask

    initial
    begin
        sb                   = new();
        rst_n                = 1'b0;
        rx_ch.valid          = 1'b0;
        rx_ch.rx_byte        = 8'h00;
        cfg_ch.valid         = 1'b0;
        cfg_ch.parser_enable = PARSER_ENABLE_RESET;
        steady               = 1'b0;
        hold_request         = 1'b0;
        bytes_sent           = 0;
        cycle_count          = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled: kill must neither act nor latch
        write_enable(1'b0);
        send_text("M112\n");
        settle();

        write_enable(1'b1);
        send_text("\n\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("\nM876S\n7\nM108z\n");
        settle();

        hold_request = 1'b1;
        run_lines(300);
        settle();

        write_enable(1'b0);
        run_lines(250);
        settle();

        write_enable(1'b1);
        steady = 1'b1;
        run_lines(250);
        steady = 1'b0;
        run_lines(250);
        settle();

        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.owed_results.size() == 0)
            $display("emergency_command_sniffer regression: pass");
        else
            $display("emergency_command_sniffer regression: fail");
        $finish;
    end

endmodule
